// ===== rtl/uot_pkg.sv =====
// Shared types, codes and constants of the UDP-over-TCP frame parser.
package uot_pkg;

    // Parse phases.
    localparam logic [3:0] PH_HCMD    = 4'd0;
    localparam logic [3:0] PH_HTYPE   = 4'd1;
    localparam logic [3:0] PH_HDOMLEN = 4'd2;
    localparam logic [3:0] PH_HADDR   = 4'd3;
    localparam logic [3:0] PH_HPORTHI = 4'd4;
    localparam logic [3:0] PH_HPORTLO = 4'd5;
    localparam logic [3:0] PH_FTYPE   = 4'd6;
    localparam logic [3:0] PH_FDOMLEN = 4'd7;
    localparam logic [3:0] PH_FADDR   = 4'd8;
    localparam logic [3:0] PH_FPORTHI = 4'd9;
    localparam logic [3:0] PH_FPORTLO = 4'd10;
    localparam logic [3:0] PH_LENHI   = 4'd11;
    localparam logic [3:0] PH_LENLO   = 4'd12;
    localparam logic [3:0] PH_PAYLOAD = 4'd13;

    // Byte roles.
    localparam logic [3:0] ROLE_CMD     = 4'd0;
    localparam logic [3:0] ROLE_TYPE    = 4'd1;
    localparam logic [3:0] ROLE_DOMLEN  = 4'd2;
    localparam logic [3:0] ROLE_ADDR    = 4'd3;
    localparam logic [3:0] ROLE_PORTHI  = 4'd4;
    localparam logic [3:0] ROLE_PORTLO  = 4'd5;
    localparam logic [3:0] ROLE_LENHI   = 4'd6;
    localparam logic [3:0] ROLE_LENLO   = 4'd7;
    localparam logic [3:0] ROLE_PAYLOAD = 4'd8;
    localparam logic [3:0] ROLE_REJECT  = 4'd9;

    // Address kinds.
    localparam logic [1:0] KIND_NONE   = 2'd0;
    localparam logic [1:0] KIND_IPV4   = 2'd1;
    localparam logic [1:0] KIND_IPV6   = 2'd2;
    localparam logic [1:0] KIND_DOMAIN = 2'd3;

    // Configuration register indexes.
    localparam logic [2:0] REG_SOCKS_IPV4   = 3'd0;
    localparam logic [2:0] REG_SOCKS_IPV6   = 3'd1;
    localparam logic [2:0] REG_SOCKS_DOMAIN = 3'd2;
    localparam logic [2:0] REG_FRAME_IPV4   = 3'd3;
    localparam logic [2:0] REG_FRAME_IPV6   = 3'd4;
    localparam logic [2:0] REG_FRAME_DOMAIN = 3'd5;

    // Address byte counts for the fixed-size kinds.
    localparam logic [7:0] IPV4_BYTES = 8'd4;
    localparam logic [7:0] IPV6_BYTES = 8'd16;

    typedef struct packed {
        logic [7:0] socks_type_ipv4;
        logic [7:0] socks_type_ipv6;
        logic [7:0] socks_type_domain;
        logic [7:0] frame_type_ipv4;
        logic [7:0] frame_type_ipv6;
        logic [7:0] frame_type_domain;
    } cfg_t;

    typedef struct packed {
        logic [3:0]  phase;
        logic        connect_flag;
        logic [1:0]  kind;
        logic [7:0]  bytes_left;
        logic [15:0] port;
        logic [15:0] length;
        logic [15:0] payload_left;
        logic        sticky_error;
    } parse_state_t;

    typedef struct packed {
        logic [7:0]  byte_value;
        logic [3:0]  role;
        logic [1:0]  addr_kind;
        logic        connect_mode;
        logic [15:0] port_value;
        logic [15:0] payload_length;
        logic        frame_done;
        logic        frame_kind;
        logic        error_flag;
    } result_t;

endpackage

// ===== rtl/uot_ifs.sv =====
// Handshake interfaces for the byte stream, the tagged results and configuration.
interface uot_stream_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;

    modport source (output valid, output in_byte, input ready);
    modport sink   (input valid, input in_byte, output ready);
endinterface

interface uot_result_if;
    logic        valid;
    logic        ready;
    logic [7:0]  byte_value;
    logic [3:0]  role;
    logic [1:0]  addr_kind;
    logic        connect_mode;
    logic [15:0] port_value;
    logic [15:0] payload_length;
    logic        frame_done;
    logic        frame_kind;
    logic        error_flag;

    modport source (output valid, output byte_value, output role, output addr_kind,
                    output connect_mode, output port_value, output payload_length,
                    output frame_done, output frame_kind, output error_flag,
                    input ready);
    modport sink   (input valid, input byte_value, input role, input addr_kind,
                    input connect_mode, input port_value, input payload_length,
                    input frame_done, input frame_kind, input error_flag,
                    output ready);
endinterface

interface uot_cfg_if;
    logic       valid;
    logic       ready;
    logic [2:0] index;
    logic [7:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/uot_cfg_regs.sv =====
// Register file holding the six address-type codes.
module uot_cfg_regs (
    input  logic          clk,
    input  logic          rst_n,
    uot_cfg_if.sink       cfg,
    output uot_pkg::cfg_t cfg_out
);
    import uot_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    // Writes are always taken; indexes beyond the list change nothing.
    assign cfg.ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg.valid)
        begin
            case (cfg.index)
                REG_SOCKS_IPV4:   cfg_next.socks_type_ipv4   = cfg.data;
                REG_SOCKS_IPV6:   cfg_next.socks_type_ipv6   = cfg.data;
                REG_SOCKS_DOMAIN: cfg_next.socks_type_domain = cfg.data;
                REG_FRAME_IPV4:   cfg_next.frame_type_ipv4   = cfg.data;
                REG_FRAME_IPV6:   cfg_next.frame_type_ipv6   = cfg.data;
                REG_FRAME_DOMAIN: cfg_next.frame_type_domain = cfg.data;
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    // Reset loads the standard SOCKS5 and UoT type codes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.socks_type_ipv4   <= 8'd1;
            cfg_reg.socks_type_ipv6   <= 8'd4;
            cfg_reg.socks_type_domain <= 8'd3;
            cfg_reg.frame_type_ipv4   <= 8'd0;
            cfg_reg.frame_type_ipv6   <= 8'd1;
            cfg_reg.frame_type_domain <= 8'd2;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg_out = cfg_reg;

endmodule

// ===== rtl/uot_step.sv =====
// Per-byte parse step: next parser state and the tagged result for one byte.
module uot_step (
    input  logic                  [7:0] in_byte,
    input  uot_pkg::cfg_t               cfg,
    input  uot_pkg::parse_state_t       cur,
    output uot_pkg::parse_state_t       nxt,
    output uot_pkg::result_t            res
);
    import uot_pkg::*;

    // Ordered match of a type byte; first hit wins.
    function automatic logic [1:0] match_type(input logic [7:0] b, input logic [7:0] t4,
                                              input logic [7:0] t6, input logic [7:0] td);
        logic [1:0] k;
        if (b == t4)
            k = KIND_IPV4;
        else if (b == t6)
            k = KIND_IPV6;
        else if (b == td)
            k = KIND_DOMAIN;
        else
            k = KIND_NONE;
        return k;
    endfunction

    logic [3:0] phase_eff;
    logic [3:0] after_frame;
    logic [1:0] hkind;
    logic [1:0] fkind;
    logic [1:0] k;
    logic       is_hs;
    logic [7:0] bl_dec;
    logic [15:0] pl_dec;
    logic [15:0] len_lo;
    logic [3:0] role;
    logic       done;

    assign phase_eff   = (cur.phase > PH_PAYLOAD) ? PH_HCMD : cur.phase;
    assign after_frame = cur.connect_flag ? PH_LENHI : PH_FTYPE;
    assign hkind  = match_type(in_byte, cfg.socks_type_ipv4, cfg.socks_type_ipv6,
                               cfg.socks_type_domain);
    assign fkind  = match_type(in_byte, cfg.frame_type_ipv4, cfg.frame_type_ipv6,
                               cfg.frame_type_domain);
    assign bl_dec = cur.bytes_left - 8'd1;
    assign pl_dec = cur.payload_left - 16'd1;
    assign len_lo = cur.length | {8'd0, in_byte};

    // Phase transitions and field updates.
    always_comb
    begin
        nxt   = cur;
        role  = ROLE_REJECT;
        done  = 1'b0;
        k     = KIND_NONE;
        is_hs = 1'b0;
        nxt.phase = phase_eff;
        if (!cur.sticky_error)
        begin
            case (phase_eff)
                PH_HTYPE, PH_FTYPE:
                begin
                    role  = ROLE_TYPE;
                    is_hs = (phase_eff == PH_HTYPE);
                    k     = is_hs ? hkind : fkind;
                    nxt.kind = k;
                    if (k == KIND_NONE)
                        nxt.sticky_error = 1'b1;
                    else if (k == KIND_DOMAIN)
                        nxt.phase = is_hs ? PH_HDOMLEN : PH_FDOMLEN;
                    else
                    begin
                        nxt.bytes_left = (k == KIND_IPV4) ? IPV4_BYTES : IPV6_BYTES;
                        nxt.phase = is_hs ? PH_HADDR : PH_FADDR;
                    end
                end
                PH_HDOMLEN, PH_FDOMLEN:
                begin
                    role = ROLE_DOMLEN;
                    if (in_byte == 8'd0)
                        nxt.sticky_error = 1'b1;
                    else
                    begin
                        nxt.bytes_left = in_byte;
                        nxt.phase = (phase_eff == PH_HDOMLEN) ? PH_HADDR : PH_FADDR;
                    end
                end
                PH_HADDR, PH_FADDR:
                begin
                    role = ROLE_ADDR;
                    nxt.bytes_left = bl_dec;
                    if (bl_dec == 8'd0)
                        nxt.phase = (phase_eff == PH_HADDR) ? PH_HPORTHI : PH_FPORTHI;
                end
                PH_HPORTHI, PH_FPORTHI:
                begin
                    role = ROLE_PORTHI;
                    nxt.port = {in_byte, 8'd0};
                    nxt.phase = (phase_eff == PH_HPORTHI) ? PH_HPORTLO : PH_FPORTLO;
                end
                PH_HPORTLO:
                begin
                    role = ROLE_PORTLO;
                    nxt.port = cur.port | {8'd0, in_byte};
                    done = 1'b1;
                    nxt.phase = after_frame;
                end
                PH_FPORTLO:
                begin
                    role = ROLE_PORTLO;
                    nxt.port = cur.port | {8'd0, in_byte};
                    nxt.phase = PH_LENHI;
                end
                PH_LENHI:
                begin
                    role = ROLE_LENHI;
                    nxt.length = {in_byte, 8'd0};
                    nxt.phase = PH_LENLO;
                end
                PH_LENLO:
                begin
                    role = ROLE_LENLO;
                    nxt.length = len_lo;
                    if (len_lo == 16'd0)
                    begin
                        done = 1'b1;
                        nxt.phase = after_frame;
                    end
                    else
                    begin
                        nxt.payload_left = len_lo;
                        nxt.phase = PH_PAYLOAD;
                    end
                end
                PH_PAYLOAD:
                begin
                    role = ROLE_PAYLOAD;
                    nxt.payload_left = pl_dec;
                    if (pl_dec == 16'd0)
                    begin
                        done = 1'b1;
                        nxt.phase = after_frame;
                    end
                end
                default:
                begin
                    role = ROLE_CMD;
                    nxt.connect_flag = (in_byte != 8'd0);
                    nxt.phase = PH_HTYPE;
                end
            endcase
        end
    end

    // Result fields show the state after this byte; role and frame_kind describe the byte itself.
    always_comb
    begin
        res.byte_value     = in_byte;
        res.role           = role;
        res.addr_kind      = nxt.kind;
        res.connect_mode   = nxt.connect_flag;
        res.port_value     = nxt.port;
        res.payload_length = nxt.length;
        res.frame_done     = done;
        res.frame_kind     = (phase_eff >= PH_FTYPE);
        res.error_flag     = nxt.sticky_error;
    end

endmodule

// ===== rtl/udp_over_tcp_frame_parser_core.sv =====
// An accepted byte's tagged result appears in the output register in the cycle after it is accepted.
// Throughput: one byte per clock while the result side keeps up; the parser state register updates once per byte.
// The output register frees on the same edge its result is taken, so no bubbles.
// Reset (rst_n low, asynchronous) returns the parser to the handshake command byte,
// clears all state and the error, and loads the default type codes.
module udp_over_tcp_frame_parser_core (
    input  logic          clk,
    input  logic          rst_n,
    uot_stream_if.sink    stream,
    uot_result_if.source  result,
    uot_cfg_if.sink       cfg
);
    import uot_pkg::*;

    cfg_t         cfg_cur;
    parse_state_t state_reg;
    parse_state_t state_next;
    result_t      step_res;
    result_t      out_reg;
    logic         out_valid_reg;
    logic         accept;

    uot_cfg_regs u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .cfg_out (cfg_cur)
    );

    uot_step u_step (
        .in_byte (stream.in_byte),
        .cfg     (cfg_cur),
        .cur     (state_reg),
        .nxt     (state_next),
        .res     (step_res)
    );

    // A new byte is taken whenever the output register is empty or being drained.
    assign stream.ready = !out_valid_reg || result.ready;
    assign accept       = stream.valid && stream.ready;

    // Parser state advances once per accepted transaction.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= '0;
        else if (accept)
            state_reg <= state_next;
    end

    // Output valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (accept)
            out_valid_reg <= 1'b1;
        else if (result.ready)
            out_valid_reg <= 1'b0;
    end

    // Output payload register.
    always_ff @(posedge clk)
    begin
        if (accept)
            out_reg <= step_res;
    end

    assign result.valid          = out_valid_reg;
    assign result.byte_value     = out_reg.byte_value;
    assign result.role           = out_reg.role;
    assign result.addr_kind      = out_reg.addr_kind;
    assign result.connect_mode   = out_reg.connect_mode;
    assign result.port_value     = out_reg.port_value;
    assign result.payload_length = out_reg.payload_length;
    assign result.frame_done     = out_reg.frame_done;
    assign result.frame_kind     = out_reg.frame_kind;
    assign result.error_flag     = out_reg.error_flag;

    // Once set, the error never clears outside reset.
    a_error_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.sticky_error |=> state_reg.sticky_error)
        else $error("sticky error cleared");

    // A byte taken after an error is always rejected.
    a_reject_after_error: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && state_reg.sticky_error) |=> (out_reg.role == ROLE_REJECT))
        else $error("byte after error not rejected");

    // A frame never ends on an erroneous byte.
    a_done_no_error: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_reg.frame_done) |-> !out_reg.error_flag)
        else $error("frame end flagged together with error");

    // The parser only reaches defined phases.
    a_phase_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.phase <= PH_PAYLOAD)
        else $error("parser phase out of range");

endmodule

// ===== sim/tb_udp_over_tcp_frame_parser_core.sv =====
`timescale 1ns / 100ps
// Self-checking testbench that tags a random tunnel byte stream and compares every result.
module tb_udp_over_tcp_frame_parser_core;
    import uot_pkg::*;

    // Ways of programming the six type-code registers between phases.
    typedef enum int {
        PLAN_EXTREME,
        PLAN_DEFAULT,
        PLAN_ALL_EQUAL,
        PLAN_V6_IS_DOMAIN,
        PLAN_RANDOM
    } code_plan_t;

    // Indexes past the last register; writes to them must have no effect.
    localparam logic [2:0] REG_SPARE_LO = 3'd6;
    localparam logic [2:0] REG_SPARE_HI = 3'd7;
    localparam logic [7:0] CODE_DEFAULTS [0:5] = '{8'd1, 8'd4, 8'd3, 8'd0, 8'd1, 8'd2};
    localparam int PHASE_BYTES = 205;

    logic clk = 1'b0;
    logic rst_n;

    uot_stream_if stream_bus();
    uot_result_if result_bus();
    uot_cfg_if    cfg_bus();

    udp_over_tcp_frame_parser_core i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .stream (stream_bus),
        .result (result_bus),
        .cfg    (cfg_bus)
    );

    // 50 MHz clock.
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Parser state mirrored by the tag predictor.
    logic [7:0]  type_code [0:5];
    logic [3:0]  parse_phase;
    logic        conn_flag;
    logic [1:0]  cur_kind;
    logic [7:0]  addr_left;
    logic [15:0] port_acc;
    logic [15:0] len_acc;
    logic [15:0] payload_left;
    logic        err_latched;

    result_t     expected_tags [$];
    logic [7:0]  stream_bytes [$];
    int unsigned bytes_queued = 0;
    int unsigned bytes_taken = 0;
    int unsigned results_seen = 0;
    int unsigned fail_count = 0;
    int unsigned feed_calm = 0;
    int unsigned drain_calm = 0;
    bit          feed_spent = 1'b0;
    bit          drain_spent = 1'b0;
    bit          connect_run;

    // Map a type byte to an address kind; the first matching register wins.
    function automatic logic [1:0] decode_type(input logic [7:0] b, input logic in_frame);
        logic [2:0] base;
        base = in_frame ? REG_FRAME_IPV4 : REG_SOCKS_IPV4;
        if (b == type_code[base])
            return KIND_IPV4;
        if (b == type_code[base + 3'd1])
            return KIND_IPV6;
        if (b == type_code[base + 3'd2])
            return KIND_DOMAIN;
        return KIND_NONE;
    endfunction

    function automatic logic [3:0] next_frame_phase();
        return conn_flag ? PH_LENHI : PH_FTYPE;
    endfunction

    // Advance the mirrored parser by one byte and return the tag it should produce.
    function automatic result_t tag_byte(input logic [7:0] b);
        result_t    tag;
        logic [1:0] k;
        logic [3:0] role;
        logic       done;
        logic       in_frame;
        role = ROLE_REJECT;
        done = 1'b0;
        if (parse_phase > PH_PAYLOAD)
            parse_phase = PH_HCMD;
        in_frame = (parse_phase >= PH_FTYPE);
        if (!err_latched)
        begin
            case (parse_phase)
                PH_HTYPE, PH_FTYPE:
                begin
                    role = ROLE_TYPE;
                    k = decode_type(b, in_frame);
                    cur_kind = k;
                    if (k == KIND_NONE)
                        err_latched = 1'b1;
                    else if (k == KIND_DOMAIN)
                        parse_phase = in_frame ? PH_FDOMLEN : PH_HDOMLEN;
                    else
                    begin
                        addr_left = (k == KIND_IPV4) ? IPV4_BYTES : IPV6_BYTES;
                        parse_phase = in_frame ? PH_FADDR : PH_HADDR;
                    end
                end
                PH_HDOMLEN, PH_FDOMLEN:
                begin
                    role = ROLE_DOMLEN;
                    if (b == 8'h00)
                        err_latched = 1'b1;
                    else
                    begin
                        addr_left = b;
                        parse_phase = in_frame ? PH_FADDR : PH_HADDR;
                    end
                end
                PH_HADDR, PH_FADDR:
                begin
                    role = ROLE_ADDR;
                    addr_left = addr_left - 8'd1;
                    if (addr_left == 8'd0)
                        parse_phase = in_frame ? PH_FPORTHI : PH_HPORTHI;
                end
                PH_HPORTHI, PH_FPORTHI:
                begin
                    role = ROLE_PORTHI;
                    port_acc = {b, 8'h00};
                    parse_phase = in_frame ? PH_FPORTLO : PH_HPORTLO;
                end
                PH_HPORTLO:
                begin
                    role = ROLE_PORTLO;
                    port_acc = port_acc | {8'h00, b};
                    done = 1'b1;
                    parse_phase = next_frame_phase();
                end
                PH_FPORTLO:
                begin
                    role = ROLE_PORTLO;
                    port_acc = port_acc | {8'h00, b};
                    parse_phase = PH_LENHI;
                end
                PH_LENHI:
                begin
                    role = ROLE_LENHI;
                    len_acc = {b, 8'h00};
                    parse_phase = PH_LENLO;
                end
                PH_LENLO:
                begin
                    role = ROLE_LENLO;
                    len_acc = len_acc | {8'h00, b};
                    if (len_acc == 16'd0)
                    begin
                        done = 1'b1;
                        parse_phase = next_frame_phase();
                    end
                    else
                    begin
                        payload_left = len_acc;
                        parse_phase = PH_PAYLOAD;
                    end
                end
                PH_PAYLOAD:
                begin
                    role = ROLE_PAYLOAD;
                    payload_left = payload_left - 16'd1;
                    if (payload_left == 16'd0)
                    begin
                        done = 1'b1;
                        parse_phase = next_frame_phase();
                    end
                end
                default:
                begin
                    role = ROLE_CMD;
                    conn_flag = (b != 8'h00);
                    parse_phase = PH_HTYPE;
                end
            endcase
        end
        tag.byte_value     = b;
        tag.role           = role;
        tag.addr_kind      = cur_kind;
        tag.connect_mode   = conn_flag;
        tag.port_value     = port_acc;
        tag.payload_length = len_acc;
        tag.frame_done     = done;
        tag.frame_kind     = in_frame;
        tag.error_flag     = err_latched;
        return tag;
    endfunction

    // Random idling: about 11 percent of calls idle, with one calm stretch per side.
    function automatic bit take_gap(inout int unsigned calm, inout bit spent);
        if (calm != 0)
        begin
            calm--;
            return 1'b0;
        end
        if (!spent && $urandom_range(0, 299) == 0)
        begin
            spent = 1'b1;
            calm = $urandom_range(150, 400);
            return 1'b0;
        end
        return ($urandom_range(0, 99) < 11);
    endfunction

    task automatic report_mismatch(input string msg);
        fail_count++;
        $display("%0t ns: result %0d: %s", $time, results_seen, msg);
    endtask

    task automatic check_field(input string name, input logic [15:0] got,
                               input logic [15:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s is %0h, expected %0h", name, got, want));
    endtask

    // Stream driver: predicts each accepted transaction and offers the next byte.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stream_bus.valid   <= 1'b0;
            stream_bus.in_byte <= 8'h00;
        end
        else
        begin
            if (stream_bus.valid && stream_bus.ready)
            begin
                expected_tags.insert(expected_tags.size(), tag_byte(stream_bus.in_byte));
                bytes_taken++;
            end
            if (!stream_bus.valid || stream_bus.ready)
            begin
                if (stream_bytes.size() != 0 && !take_gap(feed_calm, feed_spent))
                begin
                    stream_bus.valid   <= 1'b1;
                    stream_bus.in_byte <= stream_bytes.pop_front();
                end
                else
                begin
                    stream_bus.valid   <= 1'b0;
                    stream_bus.in_byte <= 8'($urandom);
                end
            end
        end
    end

    // Result monitor: compares each result transaction with the oldest expected tag.
    always @(posedge clk or negedge rst_n)
    begin
        result_t want;
        if (!rst_n)
            result_bus.ready <= 1'b0;
        else
        begin
            if (result_bus.valid && result_bus.ready)
            begin
                if (expected_tags.size() == 0)
                    report_mismatch($sformatf("unexpected result, byte %02h",
                                              result_bus.byte_value));
                else
                begin
                    want = expected_tags.pop_front();
                    check_field("byte_value", 16'(result_bus.byte_value),
                                16'(want.byte_value));
                    check_field("role", 16'(result_bus.role), 16'(want.role));
                    check_field("addr_kind", 16'(result_bus.addr_kind),
                                16'(want.addr_kind));
                    check_field("connect_mode", 16'(result_bus.connect_mode),
                                16'(want.connect_mode));
                    check_field("port_value", result_bus.port_value, want.port_value);
                    check_field("payload_length", result_bus.payload_length,
                                want.payload_length);
                    check_field("frame_done", 16'(result_bus.frame_done),
                                16'(want.frame_done));
                    check_field("frame_kind", 16'(result_bus.frame_kind),
                                16'(want.frame_kind));
                    check_field("error_flag", 16'(result_bus.error_flag),
                                16'(want.error_flag));
                end
                results_seen++;
            end
            result_bus.ready <= !take_gap(drain_calm, drain_spent);
        end
    end

    // One register write; the caller lowers valid after its last write.
    task automatic write_code(input logic [2:0] idx, input logic [7:0] val);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= idx;
        cfg_bus.data  <= val;
        do
            @(posedge clk);
        while (!cfg_bus.ready);
        if (idx <= REG_FRAME_DOMAIN)
            type_code[idx] = val;
    endtask

    task automatic program_codes(input code_plan_t plan);
        logic [7:0] a;
        logic [7:0] b;
        int         i;
        a = 8'($urandom);
        b = a ^ 8'($urandom_range(1, 255));
        case (plan)
            PLAN_EXTREME:
            begin
                write_code(REG_SOCKS_IPV4, 8'hFF);
                write_code(REG_SOCKS_IPV6, 8'h00);
                write_code(REG_SOCKS_DOMAIN, 8'($urandom_range(1, 254)));
                write_code(REG_FRAME_IPV4, 8'h00);
                write_code(REG_FRAME_IPV6, 8'hFF);
                write_code(REG_FRAME_DOMAIN, 8'($urandom_range(1, 254)));
            end
            PLAN_DEFAULT:
                for (i = 0; i < 6; i++)
                    write_code(3'(i), CODE_DEFAULTS[i]);
            PLAN_ALL_EQUAL:
            begin
                write_code(REG_SOCKS_IPV4, b);
                write_code(REG_SOCKS_IPV6, b);
                write_code(REG_SOCKS_DOMAIN, b);
                write_code(REG_FRAME_IPV4, a);
                write_code(REG_FRAME_IPV6, a);
                write_code(REG_FRAME_DOMAIN, a);
            end
            PLAN_V6_IS_DOMAIN:
            begin
                write_code(REG_SOCKS_IPV4, b);
                write_code(REG_SOCKS_IPV6, a);
                write_code(REG_SOCKS_DOMAIN, a);
                write_code(REG_FRAME_IPV4, a);
                write_code(REG_FRAME_IPV6, b);
                write_code(REG_FRAME_DOMAIN, b);
            end
            default:
                for (i = 0; i < 6; i++)
                    write_code(3'(i), 8'($urandom));
        endcase
        write_code($urandom_range(0, 1) ? REG_SPARE_LO : REG_SPARE_HI, 8'($urandom));
        cfg_bus.valid <= 1'b0;
    endtask

    task automatic push_byte(input logic [7:0] b);
        stream_bytes.insert(stream_bytes.size(), b);
        bytes_queued++;
    endtask

    // Type byte, address and port; a kind of none picks any reachable kind.
    task automatic push_endpoint(input logic in_frame, input logic [1:0] want,
                                 input int dom_len, input logic [15:0] port);
        logic [2:0] base;
        logic [7:0] code;
        logic [1:0] kind;
        int         n;
        int         r;
        base = in_frame ? REG_FRAME_IPV4 : REG_SOCKS_IPV4;
        code = type_code[base + 3'($urandom_range(0, 2))];
        for (r = 0; r < 3; r++)
            if (want != KIND_NONE && decode_type(type_code[base + 3'(r)], in_frame) == want)
                code = type_code[base + 3'(r)];
        kind = decode_type(code, in_frame);
        push_byte(code);
        if (kind == KIND_DOMAIN)
        begin
            if (dom_len > 0)
                n = dom_len;
            else if ($urandom_range(0, 15) == 0)
                n = $urandom_range(1, 255);
            else
                n = $urandom_range(1, 12);
            push_byte(8'(n));
        end
        else
            n = (kind == KIND_IPV4) ? 4 : 16;
        repeat (n)
            push_byte(8'($urandom));
        push_byte(port[15:8]);
        push_byte(port[7:0]);
    endtask

    task automatic push_frame_body(input int len);
        push_byte(8'(len >> 8));
        push_byte(8'(len));
        repeat (len)
            push_byte(8'($urandom));
    endtask

    // Mostly short frames, some empty ones and a few past 255 bytes.
    task automatic push_frame();
        int len;
        if ($urandom_range(0, 7) == 0)
            len = 0;
        else if ($urandom_range(0, 39) == 0)
            len = $urandom_range(256, 270);
        else
            len = $urandom_range(1, 24);
        if (!connect_run)
            push_endpoint(1'b1, KIND_NONE, 0, 16'($urandom));
        push_frame_body(len);
    endtask

    // Wait until every byte is taken and every tag has been checked.
    task automatic wait_drained();
        do
            @(posedge clk);
        while (bytes_taken != bytes_queued || expected_tags.size() != 0);
        repeat (4)
            @(posedge clk);
    endtask

    // Stimulus sequence.
    initial
    begin
        code_plan_t plan_seq [0:4];
        int         p;
        int unsigned target;
        logic [7:0] bad;
        plan_seq = '{PLAN_DEFAULT, PLAN_ALL_EQUAL, PLAN_V6_IS_DOMAIN, PLAN_RANDOM, PLAN_RANDOM};

        rst_n              = 1'b0;
        stream_bus.valid   = 1'b0;
        stream_bus.in_byte = 8'h00;
        result_bus.ready   = 1'b0;
        cfg_bus.valid      = 1'b0;
        cfg_bus.index      = REG_SOCKS_IPV4;
        cfg_bus.data       = 8'h00;
        type_code          = CODE_DEFAULTS;
        parse_phase        = PH_HCMD;
        conn_flag          = 1'b0;
        cur_kind           = KIND_NONE;
        addr_left          = 8'd0;
        port_acc           = 16'd0;
        len_acc            = 16'd0;
        payload_left       = 16'd0;
        err_latched        = 1'b0;
        connect_run        = ($urandom_range(0, 3) == 0);

        repeat (7)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part: handshake with the highest port, then empty and short frames.
        program_codes(PLAN_EXTREME);
        push_byte(connect_run ? 8'($urandom_range(1, 255)) : 8'h00);
        push_endpoint(1'b0, KIND_NONE, 1, 16'hFFFF);
        if (connect_run)
        begin
            push_frame_body(0);
            push_frame_body(1);
            push_frame_body(2);
        end
        else
        begin
            push_endpoint(1'b1, KIND_IPV4, 0, 16'h0000);
            push_frame_body(0);
            push_endpoint(1'b1, KIND_DOMAIN, 1, 16'h8001);
            push_frame_body(1);
        end
        wait_drained();

        // Random frames under a new set of type codes in each phase.
        for (p = 0; p < 5; p++)
        begin
            program_codes(plan_seq[p]);
            target = bytes_queued + PHASE_BYTES;
            while (bytes_queued < target)
                push_frame();
            wait_drained();
        end

        // Outside connect mode, a broken frame header latches the error; the bytes after it are rejected.
        if (!connect_run)
        begin
            push_frame();
            if (decode_type(type_code[REG_FRAME_DOMAIN], 1'b1) == KIND_DOMAIN
                && $urandom_range(0, 1))
            begin
                push_byte(type_code[REG_FRAME_DOMAIN]);
                push_byte(8'h00);
            end
            else
            begin
                bad = 8'($urandom);
                while (decode_type(bad, 1'b1) != KIND_NONE)
                    bad = 8'($urandom);
                push_byte(bad);
            end
        end
        repeat (24)
            push_byte(8'($urandom));
        wait_drained();
        repeat (8)
            @(posedge clk);

        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    // Watchdog against a hung handshake.
    initial
    begin
        #4_000_000;
        $display("Test completed with failures");
        $finish;
    end

endmodule
